FILE: src/sob_pkg.sv
`default_nettype none

package sob_pkg;

	localparam int FILL_W      = 8;
	localparam int ENTRY_W     = 48;
	localparam int IN_TDATA_W  = 144;
	localparam int OUT_TDATA_W = 64;

	localparam logic [1:0] CMD_SUBMIT = 2'd0;
	localparam logic [1:0] CMD_EOF    = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	localparam logic [15:0]        LOW_HIDDEN  = 16'h0200;
	localparam logic [ENTRY_W-1:0] ENTRY_RESET = 48'h0000_0000_0200;

	// first field in the lowest bits, so listed last
	typedef struct packed {
		logic [3:0]         pad;
		logic [6:0]         read_index;
		logic [15:0]        base_block;
		logic signed [15:0] template_dy;
		logic signed [15:0] template_dx;
		logic [31:0]        template_attr;
		logic [15:0]        tile_offset;
		logic [3:0]         palette;
		logic               sprite_hidden;
		logic signed [15:0] sprite_y;
		logic signed [15:0] sprite_x;
	} sob_in_t;

	typedef struct packed {
		logic               pad;
		logic [FILL_W-1:0]  entry_count;
		logic [15:0]        attr_two;
		logic [31:0]        attr_low_word;
		logic [6:0]         entry_index;
	} sob_out_t;

	typedef struct packed {
		logic        keep;
		logic [15:0] attr_two;
		logic [31:0] attr_low_word;
	} sob_place_t;

	// object size table, index = shape * 4 + size
	function automatic logic [6:0] obj_width(input logic [3:0] sz);
		logic [6:0] w;
		case (sz)
			4'd0:  w = 7'd8;
			4'd1:  w = 7'd16;
			4'd2:  w = 7'd32;
			4'd3:  w = 7'd64;
			4'd4:  w = 7'd16;
			4'd5:  w = 7'd32;
			4'd6:  w = 7'd32;
			4'd7:  w = 7'd64;
			4'd8:  w = 7'd8;
			4'd9:  w = 7'd8;
			4'd10: w = 7'd16;
			4'd11: w = 7'd32;
			default: w = 7'd0;
		endcase
		return w;
	endfunction

	function automatic logic [6:0] obj_height(input logic [3:0] sz);
		logic [6:0] h;
		case (sz)
			4'd0:  h = 7'd8;
			4'd1:  h = 7'd16;
			4'd2:  h = 7'd32;
			4'd3:  h = 7'd64;
			4'd4:  h = 7'd8;
			4'd5:  h = 7'd8;
			4'd6:  h = 7'd16;
			4'd7:  h = 7'd32;
			4'd8:  h = 7'd16;
			4'd9:  h = 7'd32;
			4'd10: h = 7'd32;
			4'd11: h = 7'd64;
			default: h = 7'd0;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

FILE: src/sob_mem.sv
`default_nettype none

module sob_mem #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [sob_pkg::ENTRY_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr,
	output logic      [sob_pkg::ENTRY_W-1:0] rdata
);
	import sob_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [DEPTH-1:0]   valid_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// entries never written read as the reset pattern
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_valid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : ENTRY_RESET;

endmodule

`default_nettype wire

FILE: src/sob_place.sv
`default_nettype none

module sob_place (
	input  wire sob_pkg::sob_in_t req,
	input  wire logic             fill_ok,
	output sob_pkg::sob_place_t   place
);
	import sob_pkg::*;

	logic signed [16:0] left;
	logic signed [16:0] top;
	logic [17:0]        right;
	logic [17:0]        bottom;
	logic [3:0]         sz;
	logic [6:0]         w;
	logic [6:0]         h;

	assign left   = {req.sprite_x[15], req.sprite_x} + {req.template_dx[15], req.template_dx};
	assign top    = {req.sprite_y[15], req.sprite_y} + {req.template_dy[15], req.template_dy};
	assign sz     = {req.template_attr[15:14], req.template_attr[31:30]};
	assign w      = obj_width(sz);
	assign h      = obj_height(sz);
	assign right  = {left[16], left} + {11'b0, w};
	assign bottom = {top[16], top} + {11'b0, h};

	assign place.keep = !req.sprite_hidden && fill_ok &&
		(left < 17'sd240) && (top < 17'sd160) && !right[17] && !bottom[17];
	assign place.attr_low_word = {7'b0, left[8:0], 8'b0, top[7:0]} | req.template_attr;
	assign place.attr_two      = {req.palette, req.base_block[11:0]} + req.tile_offset;

endmodule

`default_nettype wire

FILE: src/sprite_oam_entry_builder.sv
// Channel  Dir  Bus          Fields (low bit up)
// s_*      in   tuser[1:0]   command
//               tdata[143:0] sprite_x, sprite_y, sprite_hidden, palette, tile_offset,
//                            template_attr, template_dx, template_dy, base_block,
//                            read_index, zero pad
// m_*      out  tuser        written
//               tdata[63:0]  entry_index, attr_low_word, attr_two, entry_count, zero pad
//
// One request at a time. For a read, the memory read is issued in the accept cycle. At
// end of frame the walk starts at the fill count and hides entries until it meets one
// already hidden or runs off the end of the store; the walk does one read-modify-write
// per cycle on the store's single write port.
// No clearing pass after reset: per-entry valid flops make unwritten entries read hidden.
// A stalled result sits in the output register; the block waits to finish the next one.
`default_nettype none

module sprite_oam_entry_builder #(
	parameter int OAM_ENTRIES = 128
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// sprite_x, sprite_y, sprite_hidden, palette, tile_offset, template_attr,
	// template_dx, template_dy, base_block, read_index, zero pad
	input  wire logic [sob_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [1:0]                      s_tuser,   // command
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// entry_index, attr_low_word, attr_two, entry_count, zero pad
	output logic      [sob_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic                                 m_tuser    // written
);
	import sob_pkg::*;

	localparam int IDX_W = (OAM_ENTRIES > 1) ? $clog2(OAM_ENTRIES) : 1;
	localparam logic [FILL_W-1:0] N_ENTRIES = FILL_W'(OAM_ENTRIES);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SUBMIT = 3'd1;
	localparam logic [2:0] ST_RDWAIT = 3'd2;
	localparam logic [2:0] ST_WALK   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [FILL_W-1:0] ptr_q, ptr_d;
	logic [FILL_W-1:0] ptr_next;
	sob_in_t           req_q, in_w;
	sob_place_t        place;
	sob_out_t          out_q, out_d;
	logic              wr_q, wr_d;
	logic              m_tvalid_q;
	logic              out_free, load_out;

	logic               we, re;
	logic [IDX_W-1:0]   waddr, raddr;
	logic [ENTRY_W-1:0] wdata, rdata;

	assign in_w     = sob_in_t'(s_tdata);
	assign out_free = !m_tvalid_q || m_tready;
	assign ptr_next = ptr_q + 8'd1;

	sob_place u_place (
		.req     (req_q),
		.fill_ok (fill_q < N_ENTRIES),
		.place   (place)
	);

	sob_mem #(
		.DEPTH (OAM_ENTRIES),
		.AW    (IDX_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		ptr_d    = ptr_q;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = fill_q[IDX_W-1:0];
		wdata    = {place.attr_two, place.attr_low_word};
		raddr    = fill_q[IDX_W-1:0];
		load_out = 1'b0;
		wr_d     = 1'b0;
		out_d    = '0;
		out_d.entry_count = fill_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						CMD_SUBMIT: state_d = ST_SUBMIT;
						CMD_EOF: begin
							if (fill_q < N_ENTRIES) begin
								re      = 1'b1;
								ptr_d   = fill_q;
								state_d = ST_WALK;
							end else begin
								fill_d  = '0;
								state_d = ST_FINISH;
							end
						end
						CMD_READ: begin
							if ({1'b0, in_w.read_index} < N_ENTRIES) begin
								re    = 1'b1;
								raddr = in_w.read_index[IDX_W-1:0];
							end
							state_d = ST_RDWAIT;
						end
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_SUBMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
					if (place.keep) begin
						we                  = 1'b1;
						fill_d              = fill_q + 8'd1;
						wr_d                = 1'b1;
						out_d.entry_index   = fill_q[6:0];
						out_d.attr_low_word = place.attr_low_word;
						out_d.attr_two      = place.attr_two;
						out_d.entry_count   = fill_q + 8'd1;
					end
				end
			end
			ST_RDWAIT: begin
				if (out_free) begin
					load_out          = 1'b1;
					state_d           = ST_IDLE;
					out_d.entry_index = req_q.read_index;
					if ({1'b0, req_q.read_index} < N_ENTRIES) begin
						out_d.attr_low_word = rdata[31:0];
						out_d.attr_two      = rdata[47:32];
					end
				end
			end
			ST_WALK: begin
				// hide the entry just read and fetch the next in the same cycle; stop at a hidden one
				if (rdata[15:0] != LOW_HIDDEN) begin
					we    = 1'b1;
					waddr = ptr_q[IDX_W-1:0];
					wdata = {rdata[ENTRY_W-1:16], LOW_HIDDEN};
					ptr_d = ptr_next;
					if (ptr_next < N_ENTRIES) begin
						re    = 1'b1;
						raddr = ptr_next[IDX_W-1:0];
					end else begin
						fill_d  = '0;
						state_d = ST_FINISH;
					end
				end else begin
					fill_d  = '0;
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			ptr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			ptr_q   <= ptr_d;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q <= in_w;
		end
		if (load_out) begin
			out_q <= out_d;
			wr_q  <= wr_d;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = wr_q;

endmodule

`default_nettype wire

FILE: src/sob_checker.sv
`default_nettype none

module sob_checker #(
	parameter int OAM_ENTRIES = 128
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata,
	input wire logic        m_tuser
);

	// one request in flight: ready drops right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while another is in flight");

	// an appended entry sits just below the new count
	a_append_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> ({1'b0, m_tdata[6:0]} + 8'd1) == m_tdata[62:55])
		else $error("appended index does not match entry count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[62:55] <= 8'(OAM_ENTRIES))
		else $error("entry count beyond store depth");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind sprite_oam_entry_builder sob_checker #(.OAM_ENTRIES(OAM_ENTRIES)) u_sob_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

FILE: sim/oam_entry_checker.sv
module oam_entry_checker
	import sob_pkg::*;
#(
	parameter int OAM_ENTRIES = 128
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	input  wire logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // sprite_x .. read_index, zero pad
	input  wire logic [1:0]             s_tuser,   // command
	input  wire logic                   m_tvalid,
	input  wire logic                   m_tready,
	input  wire logic [OUT_TDATA_W-1:0] m_tdata,   // entry_index .. entry_count, zero pad
	input  wire logic                   m_tuser,   // written
	output int                          failures,
	output int                          outstanding,
	output int                          placed
);

	typedef struct packed {
		logic        written;
		logic [6:0]  slot;
		logic [31:0] low_word;
		logic [15:0] two;
		logic [7:0]  count;
	} oam_result_t;

	// shadow copy of the attribute store
	logic [31:0] shadow_low [OAM_ENTRIES];
	logic [15:0] shadow_two [OAM_ENTRIES];
	int          fill;

	oam_result_t pending_entries [$];
	oam_result_t want;
	sob_out_t    got;

	task automatic report(input string field, input logic [31:0] exp_v, input logic [31:0] got_v);
		failures++;
		$display("%0t: mismatch on %s, expected %h got %h", $time, field, exp_v, got_v);
	endtask

	// shape selects square / wide / tall, size scales it
	function automatic void box_size(input logic [1:0] shape, input logic [1:0] size,
			output int w, output int h);
		case (shape)
			2'd0: begin
				w = 8 << size;
				h = w;
			end
			2'd1: begin
				w = (size == 2'd0) ? 16 : (size == 2'd3) ? 64 : 32;
				h = (size == 2'd3) ? 32 : (size == 2'd2) ? 16 : 8;
			end
			2'd2: begin
				w = (size == 2'd3) ? 32 : (size == 2'd2) ? 16 : 8;
				h = (size == 2'd0) ? 16 : (size == 2'd3) ? 64 : 32;
			end
			default: begin
				w = 0;
				h = 0;
			end
		endcase
	endfunction

	// applies one request to the shadow store and returns the entry it yields
	function automatic oam_result_t step_oam(input logic [1:0] cmd, input sob_in_t q);
		oam_result_t res;
		int left, top, w, h, i;
		res = '0;
		case (cmd)
			CMD_SUBMIT: begin
				left = int'($signed(q.sprite_x)) + int'($signed(q.template_dx));
				top  = int'($signed(q.sprite_y)) + int'($signed(q.template_dy));
				if (!q.sprite_hidden && fill < OAM_ENTRIES && left < 240 && top < 160) begin
					box_size(q.template_attr[15:14], q.template_attr[31:30], w, h);
					if (left + w >= 0 && top + h >= 0) begin
						res.written  = 1'b1;
						res.slot     = fill[6:0];
						res.low_word = {7'b0, left[8:0], 8'b0, top[7:0]} | q.template_attr;
						res.two      = {q.palette, q.base_block[11:0]} + q.tile_offset;
						shadow_low[fill] = res.low_word;
						shadow_two[fill] = res.two;
						fill++;
						placed++;
					end
				end
			end
			CMD_EOF: begin
				// hide stale entries until one already hidden
				for (i = fill; i < OAM_ENTRIES && shadow_low[i][15:0] != LOW_HIDDEN; i++)
					shadow_low[i][15:0] = LOW_HIDDEN;
				fill = 0;
			end
			CMD_READ: begin
				res.slot = q.read_index;
				if (int'(q.read_index) < OAM_ENTRIES) begin
					res.low_word = shadow_low[q.read_index];
					res.two      = shadow_two[q.read_index];
				end
			end
			default: ;
		endcase
		res.count = fill[7:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < OAM_ENTRIES; i++) begin
				shadow_low[i] = {16'h0, LOW_HIDDEN};
				shadow_two[i] = '0;
			end
			fill = 0;
			placed = 0;
			pending_entries.delete();
			outstanding = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_entries.size() == 0) begin
					report("unrequested result", '0, m_tdata[31:0]);
				end else begin
					want = pending_entries.pop_front();
					got  = sob_out_t'(m_tdata);
					if (m_tuser !== want.written)
						report("written", want.written, m_tuser);
					if (got.entry_index !== want.slot)
						report("entry_index", want.slot, got.entry_index);
					if (got.attr_low_word !== want.low_word)
						report("attr_low_word", want.low_word, got.attr_low_word);
					if (got.attr_two !== want.two)
						report("attr_two", want.two, got.attr_two);
					if (got.entry_count !== want.count)
						report("entry_count", want.count, got.entry_count);
				end
			end
			if (s_tvalid && s_tready)
				pending_entries.push_back(step_oam(s_tuser, sob_in_t'(s_tdata)));
			outstanding = pending_entries.size();
		end
	end

endmodule

FILE: sim/tb.sv
module tb;
	import sob_pkg::*;

	// command 3 is an unused code; the block answers it without touching the store
	localparam logic [1:0] CMD_NOP = 2'd3;

	localparam int RAND_ITEMS   = 500;
	localparam int QUIET_TAIL   = 60;   // last requests go out with no idling
	localparam int FULL_FRAME   = 200;  // one frame long enough to fill all 128 entries
	localparam int HOLD_AT      = 120;  // request count that triggers the long output stall
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = 150;
	localparam int DRAIN_LIMIT  = 5000;

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // sprite_x .. read_index, zero pad
	logic [1:0]             s_tuser  = '0;   // command
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // entry_index .. entry_count, zero pad
	logic                   m_tuser;         // written

	int failures, outstanding, placed;
	int n_sent, n_submit, n_eof, n_read, n_nop;
	bit gaps_on   = 1'b1;
	bit hold_done = 1'b0;

	sprite_oam_entry_builder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	oam_entry_checker oam_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.failures    (failures),
		.outstanding (outstanding),
		.placed      (placed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// every field random, pad cleared
	function automatic sob_in_t any_req();
		sob_in_t r;
		r.pad           = '0;
		r.read_index    = 7'($urandom);
		r.base_block    = 16'($urandom);
		r.template_dy   = 16'($urandom);
		r.template_dx   = 16'($urandom);
		r.template_attr = $urandom;
		r.tile_offset   = 16'($urandom);
		r.palette       = 4'($urandom);
		r.sprite_hidden = 1'($urandom);
		r.sprite_y      = 16'($urandom);
		r.sprite_x      = 16'($urandom);
		return r;
	endfunction

	// visible submit with chosen position and template word
	function automatic sob_in_t place_req(input int x, input int dx, input int y, input int dy,
			input logic [31:0] attr);
		sob_in_t r;
		r = any_req();
		r.sprite_x      = 16'(x);
		r.template_dx   = 16'(dx);
		r.sprite_y      = 16'(y);
		r.template_dy   = 16'(dy);
		r.template_attr = attr;
		r.sprite_hidden = 1'b0;
		return r;
	endfunction

	function automatic sob_in_t read_req(input int idx);
		sob_in_t r;
		r = any_req();
		r.read_index = 7'(idx);
		return r;
	endfunction

	// offer one request; an optional idle burst comes first
	task automatic offer(input logic [1:0] cmd, input sob_in_t req);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= req;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		n_sent++;
		case (cmd)
			CMD_SUBMIT: n_submit++;
			CMD_EOF:    n_eof++;
			CMD_READ:   n_read++;
			default:    n_nop++;
		endcase
	endtask

	// receiver: random ready bursts, plus one long hold-off so the block backs up
	initial begin
		while (!arst_n) @(posedge clk);
		forever begin
			if (n_sent >= HOLD_AT && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (gaps_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		sob_in_t    r;
		logic [1:0] cmd;
		int         flen, roll, frame, k, n_rand, guard;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// reset contents at both ends of the store, and the unused command
		offer(CMD_READ, read_req(0));
		offer(CMD_READ, read_req(127));
		offer(CMD_NOP, any_req());
		// plain 8x8 at the origin, then the same one hidden
		offer(CMD_SUBMIT, place_req(0, 0, 0, 0, 32'h0));
		r = place_req(0, 0, 0, 0, 32'h0);
		r.sprite_hidden = 1'b1;
		offer(CMD_SUBMIT, r);
		// left and top edges: box just touching the screen is kept, one more pixel is not
		offer(CMD_SUBMIT, place_req(-4, -4, 0, 0, 32'h0));
		offer(CMD_SUBMIT, place_req(-5, -4, 0, 0, 32'h0));
		offer(CMD_SUBMIT, place_req(10, 0, -4, -4, 32'h0));
		offer(CMD_SUBMIT, place_req(10, 0, -5, -4, 32'h0));
		// right and bottom edges
		offer(CMD_SUBMIT, place_req(200, 39, 20, 0, 32'h0));
		offer(CMD_SUBMIT, place_req(200, 40, 20, 0, 32'h0));
		offer(CMD_SUBMIT, place_req(20, 0, 100, 59, 32'h0));
		offer(CMD_SUBMIT, place_req(20, 0, 100, 60, 32'h0));
		// shape 3 has a zero-size box: kept at the origin, dropped one pixel left
		offer(CMD_SUBMIT, place_req(0, 0, 0, 0, 32'h4000_C000));
		offer(CMD_SUBMIT, place_req(0, -1, 0, 0, 32'h0000_C000));
		// template word 0xFFFF is an ordinary template
		offer(CMD_SUBMIT, place_req(10, 0, 10, 0, 32'h0000_FFFF));
		// position extremes: both far off, then a sum that lands at -1 with a 64x64 box
		offer(CMD_SUBMIT, place_req(32767, 32767, 32767, 32767, 32'hFFFF_FFFF));
		offer(CMD_SUBMIT, place_req(-32768, -32768, -32768, -32768, 32'h0));
		offer(CMD_SUBMIT, place_req(-32768, 32767, -32768, 32767, 32'hC000_0000));
		// attribute two wraps past 16 bits
		r = place_req(50, 0, 50, 0, 32'h0);
		r.base_block  = 16'hFFFF;
		r.palette     = 4'hF;
		r.tile_offset = 16'hFFFF;
		offer(CMD_SUBMIT, r);
		offer(CMD_READ, read_req(5));
		offer(CMD_EOF, any_req());
		offer(CMD_READ, read_req(5));
		// short frame so the next end of frame walks over stale entries
		offer(CMD_SUBMIT, place_req(30, 0, 30, 0, 32'h0));
		offer(CMD_EOF, any_req());

		// --- random part: frames of mostly visible submits, reads and noise ---
		frame  = 0;
		n_rand = 0;
		while (n_rand < RAND_ITEMS) begin
			flen = (frame == 1) ? FULL_FRAME : $urandom_range(0, 40);
			for (k = 0; k < flen; k++) begin
				roll = (frame == 1) ? 0 : $urandom_range(0, 99);
				r = any_req();
				if (roll < 70) begin
					cmd = CMD_SUBMIT;
					r.sprite_x      = 16'($urandom_range(0, 200));
					r.template_dx   = 16'(int'($urandom_range(0, 80)) - 40);
					r.sprite_y      = 16'($urandom_range(0, 130));
					r.template_dy   = 16'(int'($urandom_range(0, 80)) - 40);
					r.sprite_hidden = ($urandom_range(0, 7) == 0);
				end else if (roll < 78) begin
					cmd = CMD_SUBMIT;   // full-range noise, mostly off screen
				end else if (roll < 95) begin
					cmd = CMD_READ;
					if ($urandom_range(0, 1) == 0)
						r.read_index = 7'($urandom_range(0, 15));
				end else begin
					cmd = CMD_NOP;
				end
				if (n_rand >= RAND_ITEMS - QUIET_TAIL)
					gaps_on = 1'b0;
				offer(cmd, r);
				n_rand++;
			end
			if (n_rand >= RAND_ITEMS - QUIET_TAIL)
				gaps_on = 1'b0;
			offer(CMD_EOF, any_req());
			n_rand++;
			frame++;
		end
		s_tvalid <= 1'b0;

		// drain, then let any late stray result show up
		guard = 0;
		while (outstanding != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d submits (%0d placed), %0d frame ends, %0d reads, %0d no-ops.",
			n_submit, placed, n_eof, n_read, n_nop);
		$display("Output held off %0d cycles once; idle bursts both sides except the tail.",
			HOLD_CYCLES);
		if (failures == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
